// ----- rtl/core/ncrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrb_pkg
// Shared types and constants of the Newton cube-root basin pixel classifier.
// ----------------------------------------------------------------------------
package ncrb_pkg;

    localparam int FRAC_BITS           = 28;
    localparam int DEF_FRAME_WIDTH     = 1024;
    localparam int DEF_FRAME_HEIGHT    = 1024;
    localparam int DEF_ITERATION_LIMIT = 64;
    localparam int DIV_STEPS           = 41;
    localparam int CNT_W               = 6;

    localparam logic signed [33:0] Q_ONE        = 34'sd268435456;
    localparam logic signed [33:0] Q_HALF       = 34'sd134217728;
    localparam logic signed [33:0] Q_SQRT3_HALF = 34'sd232471924;

    localparam logic [1:0] CFG_PIXEL_STEP  = 2'd0;
    localparam logic [1:0] CFG_CENTER_REAL = 2'd1;
    localparam logic [1:0] CFG_CENTER_IMAG = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_MAPX, S_MAPY, S_MAPSUM,
        S_SQ1, S_SQ2, S_SQ3, S_W, S_CHK,
        S_T1, S_T2, S_T3, S_T4, S_T,
        S_M1, S_M2, S_M3, S_M4, S_M,
        S_D1, S_D2, S_DEN, S_DSET, S_DIV, S_UPD,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6
    } t_state;

    typedef enum logic [4:0] {
        MS_NONE, MS_MAPX, MS_MAPY, MS_ZRZR, MS_ZIZI, MS_ZRZI,
        MS_ZRWR, MS_ZIWI, MS_ZRWI, MS_ZIWR,
        MS_NRWR, MS_NIWI, MS_NIWR, MS_NRWI, MS_WRWR, MS_WIWI,
        MS_D0R, MS_D0I, MS_D1R, MS_D1I, MS_D2I
    } t_mul_sel;

    typedef enum logic [3:0] {
        OP_NONE, OP_MAP, OP_W, OP_T, OP_M, OP_DEN, OP_DSET, OP_DSTEP,
        OP_UPD, OP_DIST01, OP_CLASS
    } t_dp_op;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic [1:0] slot;
        t_dp_op   op;
    } t_dp_cmd;

    typedef struct packed {
        logic esc;
        logic wzero;
        logic out_busy;
        logic out_valid;
    } t_dp_status;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -70'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ncrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrb_ctrl
// Sequencer: walks the datapath through mapping, Newton steps, the
// restoring division and the final root classification.
// ----------------------------------------------------------------------------
module ncrb_ctrl
    import ncrb_pkg::*;
#(
    parameter int ITERATION_LIMIT = DEF_ITERATION_LIMIT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int ITW = $clog2(ITERATION_LIMIT + 1);

    t_state           r_state, n_state;
    logic [ITW-1:0]   r_iter, n_iter;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MAPX;
            S_MAPX:   n_state = S_MAPY;
            S_MAPY:   n_state = S_MAPSUM;
            S_MAPSUM: begin
                n_state = S_SQ1;
                n_iter  = '0;
            end
            S_SQ1:    n_state = S_SQ2;
            S_SQ2:    n_state = S_SQ3;
            S_SQ3:    n_state = S_W;
            S_W:      n_state = S_CHK;
            S_CHK: begin
                if (i_status.esc || i_status.wzero || r_iter == ITW'(ITERATION_LIMIT)) begin
                    n_state = S_C1;
                end else begin
                    n_state = S_T1;
                end
            end
            S_T1:     n_state = S_T2;
            S_T2:     n_state = S_T3;
            S_T3:     n_state = S_T4;
            S_T4:     n_state = S_T;
            S_T:      n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_M4;
            S_M4:     n_state = S_M;
            S_M:      n_state = S_D1;
            S_D1:     n_state = S_D2;
            S_D2:     n_state = S_DEN;
            S_DEN:    n_state = S_DSET;
            S_DSET: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_SQ1;
                n_iter  = r_iter + 1'b1;
            end
            S_C1:     n_state = S_C2;
            S_C2:     n_state = S_C3;
            S_C3:     n_state = S_C4;
            S_C4:     n_state = S_C5;
            S_C5:     n_state = S_C6;
            S_C6:     if (!i_status.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.mul_sel = MS_NONE;
        o_cmd.slot    = 2'd0;
        o_cmd.op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MAPX:   o_cmd.mul_sel = MS_MAPX;
            S_MAPY: begin
                o_cmd.mul_sel = MS_MAPY;
                o_cmd.slot    = 2'd1;
            end
            S_MAPSUM: o_cmd.op = OP_MAP;
            S_SQ1:    o_cmd.mul_sel = MS_ZRZR;
            S_SQ2: begin
                o_cmd.mul_sel = MS_ZIZI;
                o_cmd.slot    = 2'd1;
            end
            S_SQ3: begin
                o_cmd.mul_sel = MS_ZRZI;
                o_cmd.slot    = 2'd2;
            end
            S_W:      o_cmd.op = OP_W;
            S_T1:     o_cmd.mul_sel = MS_ZRWR;
            S_T2: begin
                o_cmd.mul_sel = MS_ZIWI;
                o_cmd.slot    = 2'd1;
            end
            S_T3: begin
                o_cmd.mul_sel = MS_ZRWI;
                o_cmd.slot    = 2'd2;
            end
            S_T4: begin
                o_cmd.mul_sel = MS_ZIWR;
                o_cmd.slot    = 2'd3;
            end
            S_T:      o_cmd.op = OP_T;
            S_M1:     o_cmd.mul_sel = MS_NRWR;
            S_M2: begin
                o_cmd.mul_sel = MS_NIWI;
                o_cmd.slot    = 2'd1;
            end
            S_M3: begin
                o_cmd.mul_sel = MS_NIWR;
                o_cmd.slot    = 2'd2;
            end
            S_M4: begin
                o_cmd.mul_sel = MS_NRWI;
                o_cmd.slot    = 2'd3;
            end
            S_M:      o_cmd.op = OP_M;
            S_D1:     o_cmd.mul_sel = MS_WRWR;
            S_D2: begin
                o_cmd.mul_sel = MS_WIWI;
                o_cmd.slot    = 2'd1;
            end
            S_DEN:    o_cmd.op = OP_DEN;
            S_DSET:   o_cmd.op = OP_DSET;
            S_DIV:    o_cmd.op = OP_DSTEP;
            S_UPD:    o_cmd.op = OP_UPD;
            S_C1:     o_cmd.mul_sel = MS_D0R;
            S_C2: begin
                o_cmd.mul_sel = MS_D0I;
                o_cmd.slot    = 2'd1;
            end
            S_C3: begin
                o_cmd.mul_sel = MS_D1R;
                o_cmd.slot    = 2'd2;
            end
            S_C4: begin
                o_cmd.mul_sel = MS_D1I;
                o_cmd.slot    = 2'd3;
            end
            // Slot 0 is reused for the third root once the first distance is summed.
            S_C5: begin
                o_cmd.mul_sel = MS_D2I;
                o_cmd.op      = OP_DIST01;
            end
            S_C6:     o_cmd.op = i_status.out_busy ? OP_NONE : OP_CLASS;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= ITW'(ITERATION_LIMIT))
        else $error("iteration count passed the limit");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < CNT_W'(DIV_STEPS))
        else $error("division ran too many steps");
    a_class_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C6 && !i_status.out_busy) |=> i_status.out_valid)
        else $error("classified pixel did not reach the output register");
`endif

endmodule

// ----- rtl/core/ncrb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrb_dp
// Datapath: configuration registers, one shared signed multiplier, product
// slots, Newton-step arithmetic, two-lane restoring divider, output register.
// ----------------------------------------------------------------------------
module ncrb_dp
    import ncrb_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [9:0]  o_out_x,
    output logic [9:0]  o_out_y,
    output logic [1:0]  o_root_sel
);

    localparam logic signed [68:0] ESC_LIM  = 69'sd1 <<< 58;
    localparam logic signed [68:0] RND28    = 69'sd1 <<< 27;
    localparam logic signed [68:0] RND27    = 69'sd1 <<< 26;
    localparam logic [40:0]        DELTA_CAP = 41'd1 << 40;

    logic [30:0]        r_step;
    logic signed [31:0] r_cre, r_cim;
    logic [9:0]         r_px, r_py;
    logic signed [31:0] r_zr, r_zi;
    logic signed [33:0] r_wre, r_wim, r_nre, r_nim;
    logic signed [68:0] r_mre, r_mim;
    logic [63:0]        r_den;
    logic               r_esc;
    logic signed [67:0] r_slot [0:3];
    logic [63:0]        r_rre, r_rim;
    logic [40:0]        r_nbre, r_nbim, r_qre, r_qim;
    logic               r_capre, r_capim, r_negre, r_negim;
    logic signed [68:0] r_d0, r_d1;
    logic               r_o_valid;
    logic [9:0]         r_ox, r_oy;
    logic [1:0]         r_root;

    logic signed [13:0] w_dx, w_dy;
    logic signed [33:0] w_a, w_b, w_zr, w_zi;
    logic signed [67:0] w_prod;
    logic signed [68:0] w_s0, w_s1, w_s2, w_s3, w_sum01, w_sum23, w_dif01, w_dif23;
    logic signed [68:0] w_d2, w_rnd_a, w_rnd_b;
    logic signed [68:0] w_den3;
    logic [63:0]        w_are, w_aim;
    logic [63:0]        w_r2re, w_r2im;
    logic [40:0]        w_qcre, w_qcim;
    logic signed [41:0] w_dlre, w_dlim;
    logic [1:0]         w_best01;
    logic signed [68:0] w_bestd01;

    assign w_dx = $signed({4'b0, r_px}) - $signed(14'(FRAME_WIDTH / 2));
    assign w_dy = $signed({4'b0, r_py}) - $signed(14'(FRAME_HEIGHT / 2));
    assign w_zr = 34'(r_zr);
    assign w_zi = 34'(r_zi);

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul_sel)
            MS_MAPX: begin w_a = 34'(w_dx); w_b = $signed({3'b0, r_step}); end
            MS_MAPY: begin w_a = 34'(w_dy); w_b = $signed({3'b0, r_step}); end
            MS_ZRZR: begin w_a = w_zr; w_b = w_zr; end
            MS_ZIZI: begin w_a = w_zi; w_b = w_zi; end
            MS_ZRZI: begin w_a = w_zr; w_b = w_zi; end
            MS_ZRWR: begin w_a = w_zr; w_b = r_wre; end
            MS_ZIWI: begin w_a = w_zi; w_b = r_wim; end
            MS_ZRWI: begin w_a = w_zr; w_b = r_wim; end
            MS_ZIWR: begin w_a = w_zi; w_b = r_wre; end
            MS_NRWR: begin w_a = r_nre; w_b = r_wre; end
            MS_NIWI: begin w_a = r_nim; w_b = r_wim; end
            MS_NIWR: begin w_a = r_nim; w_b = r_wre; end
            MS_NRWI: begin w_a = r_nre; w_b = r_wim; end
            MS_WRWR: begin w_a = r_wre; w_b = r_wre; end
            MS_WIWI: begin w_a = r_wim; w_b = r_wim; end
            MS_D0R:  begin w_a = w_zr - Q_ONE;  w_b = w_zr - Q_ONE;  end
            MS_D0I:  begin w_a = w_zi; w_b = w_zi; end
            MS_D1R:  begin w_a = w_zr + Q_HALF; w_b = w_zr + Q_HALF; end
            MS_D1I:  begin w_a = w_zi - Q_SQRT3_HALF; w_b = w_zi - Q_SQRT3_HALF; end
            MS_D2I:  begin w_a = w_zi + Q_SQRT3_HALF; w_b = w_zi + Q_SQRT3_HALF; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_prod = w_a * w_b;

    assign w_s0    = 69'(r_slot[0]);
    assign w_s1    = 69'(r_slot[1]);
    assign w_s2    = 69'(r_slot[2]);
    assign w_s3    = 69'(r_slot[3]);
    assign w_sum01 = w_s0 + w_s1;
    assign w_sum23 = w_s2 + w_s3;
    assign w_dif01 = w_s0 - w_s1;
    assign w_dif23 = w_s2 - w_s3;
    assign w_d2    = w_s2 + w_s0;
    assign w_den3  = (w_sum01 <<< 1) + w_sum01;

    // Rounding to nearest with halves upward: add half an LSB, then floor.
    assign w_rnd_a = (w_dif01 + RND28) >>> FRAC_BITS;
    assign w_rnd_b = (i_cmd.op == OP_W) ? ((w_s2 + RND27) >>> (FRAC_BITS - 1))
                                        : ((w_sum23 + RND28) >>> FRAC_BITS);

    assign w_are = r_mre[68] ? 64'(-r_mre) : 64'(r_mre);
    assign w_aim = r_mim[68] ? 64'(-r_mim) : 64'(r_mim);

    assign w_r2re = {r_rre[62:0], r_nbre[40]};
    assign w_r2im = {r_rim[62:0], r_nbim[40]};

    assign w_qcre = (r_capre || r_qre > DELTA_CAP) ? DELTA_CAP : r_qre;
    assign w_qcim = (r_capim || r_qim > DELTA_CAP) ? DELTA_CAP : r_qim;
    assign w_dlre = r_negre ? -$signed({1'b0, w_qcre}) : $signed({1'b0, w_qcre});
    assign w_dlim = r_negim ? -$signed({1'b0, w_qcim}) : $signed({1'b0, w_qcim});

    assign w_best01  = (r_d1 < r_d0) ? 2'd1 : 2'd0;
    assign w_bestd01 = (r_d1 < r_d0) ? r_d1 : r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= 31'd1048576;
            r_cre     <= '0;
            r_cim     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PIXEL_STEP:  r_step <= i_cfg_wdata[30:0];
                    CFG_CENTER_REAL: r_cre  <= i_cfg_wdata;
                    CFG_CENTER_IMAG: r_cim  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_CLASS) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.mul_sel != MS_NONE) begin
            r_slot[i_cmd.slot] <= w_prod;
        end
        case (i_cmd.op)
            OP_MAP: begin
                r_zr <= sat32(70'(w_s0) + 70'(r_cre));
                r_zi <= sat32(70'(w_s1) + 70'(r_cim));
            end
            OP_W: begin
                r_wre <= w_rnd_a[33:0];
                r_wim <= w_rnd_b[33:0];
                r_esc <= w_sum01 > ESC_LIM;
            end
            OP_T: begin
                r_nre <= w_rnd_a[33:0] - Q_ONE;
                r_nim <= w_rnd_b[33:0];
            end
            OP_M: begin
                r_mre <= w_sum01;
                r_mim <= w_dif23;
            end
            OP_DEN: r_den <= w_den3[63:0];
            OP_DSET: begin
                r_negre <= r_mre[68];
                r_negim <= r_mim[68];
                // A quotient of 2^41 or more is capped without dividing.
                r_capre <= {13'b0, w_are} >= {r_den, 13'b0};
                r_capim <= {13'b0, w_aim} >= {r_den, 13'b0};
                r_rre   <= w_are >> 13;
                r_rim   <= w_aim >> 13;
                r_nbre  <= {w_are[12:0], 28'b0};
                r_nbim  <= {w_aim[12:0], 28'b0};
                r_qre   <= '0;
                r_qim   <= '0;
            end
            OP_DSTEP: begin
                r_nbre <= r_nbre << 1;
                r_nbim <= r_nbim << 1;
                if (w_r2re >= r_den) begin
                    r_rre <= w_r2re - r_den;
                    r_qre <= {r_qre[39:0], 1'b1};
                end else begin
                    r_rre <= w_r2re;
                    r_qre <= {r_qre[39:0], 1'b0};
                end
                if (w_r2im >= r_den) begin
                    r_rim <= w_r2im - r_den;
                    r_qim <= {r_qim[39:0], 1'b1};
                end else begin
                    r_rim <= w_r2im;
                    r_qim <= {r_qim[39:0], 1'b0};
                end
            end
            OP_UPD: begin
                r_zr <= sat32(70'(r_zr) - 70'(w_dlre));
                r_zi <= sat32(70'(r_zi) - 70'(w_dlim));
            end
            OP_DIST01: begin
                r_d0 <= w_sum01;
                r_d1 <= w_sum23;
            end
            OP_CLASS: begin
                r_ox   <= r_px;
                r_oy   <= r_py;
                r_root <= (w_d2 < w_bestd01) ? 2'd2 : w_best01;
            end
            default: ;
        endcase
    end

    assign o_status.esc       = r_esc;
    assign o_status.wzero     = (r_wre == '0) && (r_wim == '0);
    assign o_status.out_busy  = r_o_valid && !i_out_ready;
    assign o_status.out_valid = r_o_valid;

    assign o_out_valid = r_o_valid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_root_sel  = r_root;

`ifndef NO_ASSERTIONS
    a_root_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_root != 2'd3)
        else $error("root index out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.op) == OP_DSTEP |-> (r_rre < r_den || r_capre))
        else $error("divider remainder not reduced");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_out_ready) |=> r_o_valid)
        else $error("pending result dropped");
`endif

endmodule

// ----- rtl/core/newton_cubic_root_basin_pixel.sv -----
`timescale 1ns / 1ps
// Each request runs N Newton steps from mapping to result (at most ITERATION_LIMIT,
// fewer on escape or a zero z^2). Each step makes 13 passes through the single
// shared multiplier, plus combine steps and a bit-per-cycle restoring divide.
// A new pixel is accepted only from the idle state, after the previous pixel is
// classified; the output register lets the next pixel start while a result waits.
// Reset is synchronous.
// ----------------------------------------------------------------------------
// newton_cubic_root_basin_pixel
// Maps a pixel to a start point, runs Newton iteration for z^3-1 in Q4.28
// and reports the nearest cube root of unity.
// ----------------------------------------------------------------------------
module newton_cubic_root_basin_pixel
    import ncrb_pkg::*;
#(
    parameter int FRAME_WIDTH     = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT    = DEF_FRAME_HEIGHT,
    parameter int ITERATION_LIMIT = DEF_ITERATION_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // out_x[9:0], out_y[19:10], root_sel[21:20]
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [9:0] w_ox, w_oy;
    logic [1:0] w_root;

    ncrb_ctrl #(
        .ITERATION_LIMIT(ITERATION_LIMIT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    ncrb_dp #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pixel_x   (i_s_axis_tdata[9:0]),
        .i_pixel_y   (i_s_axis_tdata[19:10]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_x     (w_ox),
        .o_out_y     (w_oy),
        .o_root_sel  (w_root)
    );

    assign o_m_axis_tdata = {2'b00, w_root, w_oy, w_ox};

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Newton cube-root basin pixel classifier. Pixel
// requests go in on the slave stream. Each result is compared against a Q4.28
// fixed-point prediction of the Newton iteration for z^3-1, worked out when
// the request is accepted. Several step and center settings are covered.
// ----------------------------------------------------------------------------
module tb;
    import ncrb_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [9:0] px;
        logic [9:0] py;
        logic [1:0] root;
    } t_basin;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // pixel_x[9:0], pixel_y[19:10], zero pad
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // out_x[9:0], out_y[19:10], root_sel[21:20]

    // Local copy of the configuration registers.
    logic [30:0]        step_q;
    logic signed [31:0] center_re_q;
    logic signed [31:0] center_im_q;

    t_basin expected_basins[$];
    int     mismatch_count;
    int     pixels_sent;
    int     results_seen;
    int     burst_left;
    int     stall_mode;

    newton_cubic_root_basin_pixel u_top (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_wide clamp_q(t_wide v);
        t_wide r;
        r = v;
        if (v > 128'sd2147483647) begin
            r = 128'sd2147483647;
        end else if (v < -128'sd2147483648) begin
            r = -128'sd2147483648;
        end
        return r;
    endfunction

    // Truncated quotient m * 2^28 / den, magnitude capped at 2^40.
    function automatic t_wide newton_quot(t_wide m, t_wide den);
        t_wide mag;
        t_wide q;
        mag = (m < 0) ? -m : m;
        q = (mag <<< FRAC_BITS) / den;
        if (q > (128'sd1 <<< 40)) begin
            q = 128'sd1 <<< 40;
        end
        return (m < 0) ? -q : q;
    endfunction

    function automatic logic [1:0] nearest_root(logic [9:0] px, logic [9:0] py);
        t_wide zr, zi, wr, wi, tr, ti, nr, mr, mi, den, step_w, d, best_d;
        t_wide rre[3];
        t_wide rim[3];
        int steps;
        logic [1:0] best;
        step_w = '0;
        step_w[30:0] = step_q;
        zr = clamp_q((t_wide'(px) - DEF_FRAME_WIDTH / 2) * step_w + t_wide'(center_re_q));
        zi = clamp_q((t_wide'(py) - DEF_FRAME_HEIGHT / 2) * step_w + t_wide'(center_im_q));
        steps = 0;
        while ((zr * zr + zi * zi) <= (128'sd4 <<< (2 * FRAC_BITS))
               && steps < DEF_ITERATION_LIMIT) begin
            wr = (zr * zr - zi * zi + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            wi = (zr * zi + (128'sd1 <<< (FRAC_BITS - 2))) >>> (FRAC_BITS - 1);
            if (wr == 0 && wi == 0) begin
                break;
            end
            tr = (zr * wr - zi * wi + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            ti = (zr * wi + zi * wr + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            nr = tr - t_wide'(Q_ONE);
            mr = nr * wr + ti * wi;
            mi = ti * wr - nr * wi;
            den = 3 * (wr * wr + wi * wi);
            zr = clamp_q(zr - newton_quot(mr, den));
            zi = clamp_q(zi - newton_quot(mi, den));
            steps++;
        end
        rre[0] = t_wide'(Q_ONE);
        rim[0] = 0;
        rre[1] = -t_wide'(Q_HALF);
        rim[1] = t_wide'(Q_SQRT3_HALF);
        rre[2] = -t_wide'(Q_HALF);
        rim[2] = -t_wide'(Q_SQRT3_HALF);
        best = 2'd0;
        best_d = 0;
        for (int k = 0; k < 3; k++) begin
            d = (zr - rre[k]) * (zr - rre[k]) + (zi - rim[k]) * (zi - rim[k]);
            if (k == 0 || d < best_d) begin
                best_d = d;
                best = 2'(k);
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Results are checked at the rising edge where the handshake completes.
    always @(posedge i_clk) begin
        t_basin e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_basins.size() == 0) begin
                report_mismatch("unexpected result", int'(o_m_axis_tdata), 0);
            end else begin
                e = expected_basins.pop_front();
                if (o_m_axis_tdata[9:0] !== e.px) begin
                    report_mismatch("out_x", int'(o_m_axis_tdata[9:0]), int'(e.px));
                end
                if (o_m_axis_tdata[19:10] !== e.py) begin
                    report_mismatch("out_y", int'(o_m_axis_tdata[19:10]), int'(e.py));
                end
                if (o_m_axis_tdata[21:20] !== e.root) begin
                    report_mismatch("nearest root", int'(o_m_axis_tdata[21:20]),
                                    int'(e.root));
                end
            end
        end
    end

    // Receiver back-pressure: free flow, random stalls, or long stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            stall_mode <= $urandom_range(0, 2);
        end
        case (stall_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_m_axis_tready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_pixel(logic [9:0] px, logic [9:0] py);
        t_basin e;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, py, px};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        e.px = px;
        e.py = py;
        e.root = nearest_root(px, py);
        expected_basins.push_back(e);
        pixels_sent++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            CFG_PIXEL_STEP: step_q = data[30:0];
            CFG_CENTER_REAL: center_re_q = data;
            CFG_CENTER_IMAG: center_im_q = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Holds off new requests until every pending result has come back.
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (expected_basins.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults;
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        // Center pixel maps to z = 0, so z^2 is zero and iteration stops at once.
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd768, 10'd512);
        send_pixel(10'd384, 10'd734);
        send_pixel(10'd384, 10'd290);
        send_pixel(10'd341, 10'd682);
        drain();
    endtask

    task automatic test_center_offsets;
        write_reg(CFG_CENTER_REAL, 32'sh1000_0000);
        write_reg(CFG_CENTER_IMAG, 32'sh8000_0000);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd1023);
        drain();
        write_reg(CFG_CENTER_REAL, 32'sh7FFF_FFFF);
        write_reg(CFG_CENTER_IMAG, 32'sh7FFF_FFFF);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd0);
        drain();
        // Index beyond the register list must be ignored.
        write_reg(2'd3, 32'hDEAD_BEEF);
        write_reg(CFG_CENTER_REAL, 32'd0);
        write_reg(CFG_CENTER_IMAG, 32'd0);
        send_pixel(10'd600, 10'd700);
        drain();
    endtask

    task automatic test_step_extremes;
        // Zero step: every pixel maps to the center point.
        write_reg(CFG_PIXEL_STEP, 32'd0);
        write_reg(CFG_CENTER_REAL, 32'hF800_0000);
        write_reg(CFG_CENTER_IMAG, 32'h0DDB_3D74);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd511);
        drain();
        write_reg(CFG_PIXEL_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER_REAL, 32'd0);
        write_reg(CFG_CENTER_IMAG, 32'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd513, 10'd512);
        send_pixel(10'd512, 10'd511);
        drain();
        write_reg(CFG_PIXEL_STEP, 32'd1);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd513, 10'd513);
        drain();
    endtask

    task automatic test_random_sweep(int count);
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 3 == 2) begin
                write_reg(CFG_PIXEL_STEP, $urandom() & 32'h7FFF_FFFF);
                write_reg(CFG_CENTER_REAL, $urandom());
                write_reg(CFG_CENTER_IMAG, $urandom());
            end else begin
                write_reg(CFG_PIXEL_STEP, $urandom_range(1 << 18, 1 << 22));
                write_reg(CFG_CENTER_REAL, $urandom_range(0, 1 << 28) - (1 << 27));
                write_reg(CFG_CENTER_IMAG, $urandom_range(0, 1 << 28) - (1 << 27));
            end
            for (int n = 0; n < count / 6; n++) begin
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        stall_mode      = 0;
        mismatch_count  = 0;
        pixels_sent     = 0;
        results_seen    = 0;
        burst_left      = 3;
        step_q          = 31'd1048576;
        center_re_q     = '0;
        center_im_q     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_center_offsets();
        test_step_extremes();
        test_random_sweep(570);

        repeat (50) @(negedge i_clk);
        $display("Covered %0d pixel requests and %0d results over reset, offset,", pixels_sent,
                 results_seen);
        $display("step-extreme and random view settings; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && expected_basins.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #500_000_000;
        $display("Timed out with %0d results outstanding.", expected_basins.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ncrb_pkg.sv
rtl/core/ncrb_ctrl.sv
rtl/core/ncrb_dp.sv
rtl/core/newton_cubic_root_basin_pixel.sv
verif/tb.sv
